### hdl/bicbp_pkg.sv
// Shared definitions for the binary integer constraint bounds propagator.
// Holds the constraint kind codes, the truth-variable codes and the status struct.
// No dependencies.
package bicbp_pkg;

  // Constraint kinds carried in the action field.
  typedef enum logic [3:0] {
    ACT_ABS     = 4'd0,
    ACT_EQ      = 4'd1,
    ACT_LE      = 4'd2,
    ACT_LT      = 4'd3,
    ACT_NE      = 4'd4,
    ACT_EQ_REIF = 4'd5,
    ACT_LE_REIF = 4'd6,
    ACT_LT_REIF = 4'd7,
    ACT_NE_REIF = 4'd8
  } action_e;

  // Truth-variable codes; the spare code is read as unbound.
  localparam logic [1:0] TRUTH_UNBOUND = 2'd0;
  localparam logic [1:0] TRUTH_FALSE   = 2'd1;
  localparam logic [1:0] TRUTH_TRUE    = 2'd2;
  localparam logic [1:0] TRUTH_SPARE   = 2'd3;

  // Status of one propagation, passed from the datapath to the result register.
  typedef struct packed {
    logic [1:0] truth;
    logic       a_hole_valid;
    logic       b_hole_valid;
    logic       failed;
  } status_t;

endpackage

### hdl/bicbp_core.sv
// Combinational bounds propagation for one binary integer constraint.
// Depends on bicbp_pkg for the kind codes, truth codes and status struct.
// Internal arithmetic is one bit wider than the values, so negation never overflows.
module bicbp_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  bicbp_pkg::action_e              action_i,
  input  logic signed [VALUE_WIDTH-1:0]   a_low_i,
  input  logic signed [VALUE_WIDTH-1:0]   a_high_i,
  input  logic signed [VALUE_WIDTH-1:0]   b_low_i,
  input  logic signed [VALUE_WIDTH-1:0]   b_high_i,
  input  logic [1:0]                      truth_i,
  output logic signed [VALUE_WIDTH-1:0]   new_a_low_o,
  output logic signed [VALUE_WIDTH-1:0]   new_a_high_o,
  output logic signed [VALUE_WIDTH-1:0]   new_b_low_o,
  output logic signed [VALUE_WIDTH-1:0]   new_b_high_o,
  output logic signed [VALUE_WIDTH-1:0]   a_hole_value_o,
  output logic signed [VALUE_WIDTH-1:0]   b_hole_value_o,
  output bicbp_pkg::status_t              status_o
);
  import bicbp_pkg::*;

  localparam int ExtWidth = VALUE_WIDTH + 1;
  // At 64 bits and wider the limits of the value range saturate instead of growing.
  localparam bit Saturate = (VALUE_WIDTH >= 64);

  typedef logic signed [ExtWidth-1:0] ext_t;

  typedef struct packed {
    ext_t lo;
    ext_t hi;
  } rng_t;

  typedef struct packed {
    rng_t x;
    rng_t y;
    logic fail;
  } le_res_t;

  typedef struct packed {
    rng_t d;
    logic hole;
    logic fail;
  } rm_res_t;

  localparam ext_t MaxV = {2'b00, {(VALUE_WIDTH-1){1'b1}}};
  localparam ext_t MinV = {2'b11, {(VALUE_WIDTH-1){1'b0}}};
  localparam ext_t Zero = '0;
  localparam ext_t One  = ext_t'(1);

  function automatic ext_t neg_f(ext_t x);
    ext_t r;
    r = -x;
    if (Saturate && (r > MaxV)) r = MaxV;
    return r;
  endfunction

  function automatic ext_t inc_f(ext_t x);
    ext_t r;
    r = x + One;
    if (Saturate && (r > MaxV)) r = MaxV;
    return r;
  endfunction

  function automatic ext_t dec_f(ext_t x);
    ext_t r;
    r = x - One;
    if (Saturate && (r < MinV)) r = MinV;
    return r;
  endfunction

  function automatic ext_t max_f(ext_t x, ext_t y);
    return (x > y) ? x : y;
  endfunction

  function automatic ext_t min_f(ext_t x, ext_t y);
    return (x < y) ? x : y;
  endfunction

  // x <= y, or x < y when strict; both sides use the bounds as they arrived.
  function automatic le_res_t le_f(rng_t x, rng_t y, logic strict);
    le_res_t res;
    ext_t    lim_hi;
    ext_t    lim_lo;
    lim_hi    = strict ? dec_f(y.hi) : y.hi;
    lim_lo    = strict ? inc_f(x.lo) : x.lo;
    res.x.lo  = x.lo;
    res.x.hi  = min_f(x.hi, lim_hi);
    res.y.lo  = max_f(y.lo, lim_lo);
    res.y.hi  = y.hi;
    res.fail  = (res.x.lo > res.x.hi) || (res.y.lo > res.y.hi);
    return res;
  endfunction

  // Removal of one value: a bound moves by one, an inner value raises a hole, removing the only value fails.
  function automatic rm_res_t rm_f(rng_t d, ext_t v);
    rm_res_t res;
    res.d    = d;
    res.hole = 1'b0;
    res.fail = 1'b0;
    if (!((v < d.lo) || (v > d.hi))) begin
      if (d.lo == d.hi) begin
        res.fail = 1'b1;
      end else if (v == d.lo) begin
        res.d.lo = v + One;
      end else if (v == d.hi) begin
        res.d.hi = v - One;
      end else begin
        res.hole = 1'b1;
      end
    end
    return res;
  endfunction

  always_comb begin
    rng_t    a0, b0, a_res, b_res;
    rng_t    eq_rng, ab1, ab2, aa;
    rm_res_t rm_a, rm_b;
    le_res_t le_ab, le_ba;
    ext_t    t_lo, t_hi;
    logic    empty, eq_fail, ne_fail, abs_fail;
    logic    a_fixed, b_fixed, disjoint, same_fixed;
    logic    ab_strict, ba_strict, a_pos, a_nonpos;
    logic    reif, cond_t, cond_f, assign_fail, prop_fail, fail;
    logic    is_t, is_f;
    logic    sel_abs, sel_eq, sel_ne, sel_le_ab, sel_le_ba;
    logic    hole_a, hole_b;
    logic [1:0] r0, r1;

    a0.lo = ext_t'(a_low_i);
    a0.hi = ext_t'(a_high_i);
    b0.lo = ext_t'(b_low_i);
    b0.hi = ext_t'(b_high_i);
    r0    = (truth_i == TRUTH_SPARE) ? TRUTH_UNBOUND : truth_i;

    empty      = (a0.lo > a0.hi) || (b0.lo > b0.hi);
    a_fixed    = (a0.lo == a0.hi);
    b_fixed    = (b0.lo == b0.hi);
    disjoint   = (a0.hi < b0.lo) || (b0.hi < a0.lo);
    same_fixed = a_fixed && b_fixed && (a0.lo == b0.lo);

    // Equality: both domains become the intersection.
    eq_rng.lo = max_f(a0.lo, b0.lo);
    eq_rng.hi = min_f(a0.hi, b0.hi);
    eq_fail   = (eq_rng.lo > eq_rng.hi);

    // Disequality: a fixed side removes its value from the other side.
    rm_b    = rm_f(b0, a0.lo);
    rm_a    = rm_f(a0, b0.lo);
    ne_fail = (a_fixed && rm_b.fail) || (b_fixed && rm_a.fail);

    // Ordering in both directions, strictness chosen by the kind.
    ab_strict = (action_i == ACT_LT) || (action_i == ACT_LT_REIF);
    ba_strict = (action_i == ACT_LE_REIF);
    le_ab     = le_f(a0, b0, ab_strict);
    le_ba     = le_f(b0, a0, ba_strict);

    // Absolute value: b >= 0, then b from |a|, then a from the new b.
    a_pos    = (a0.lo >= Zero);
    a_nonpos = (a0.hi <= Zero);
    ab1.lo   = max_f(b0.lo, Zero);
    ab1.hi   = b0.hi;
    if (a_pos) begin
      t_lo = a0.lo;
      t_hi = a0.hi;
    end else if (a_nonpos) begin
      t_lo = neg_f(a0.hi);
      t_hi = neg_f(a0.lo);
    end else begin
      t_lo = Zero;
      t_hi = max_f(neg_f(a0.lo), a0.hi);
    end
    ab2.lo = max_f(ab1.lo, t_lo);
    ab2.hi = min_f(ab1.hi, t_hi);
    if (a_pos) begin
      t_lo = ab2.lo;
      t_hi = ab2.hi;
    end else if (a_nonpos) begin
      t_lo = neg_f(ab2.hi);
      t_hi = neg_f(ab2.lo);
    end else begin
      t_lo = neg_f(ab2.hi);
      t_hi = ab2.hi;
    end
    aa.lo    = max_f(a0.lo, t_lo);
    aa.hi    = min_f(a0.hi, t_hi);
    abs_fail = (ab1.lo > ab1.hi) || (ab2.lo > ab2.hi) || (aa.lo > aa.hi);

    // Conditions under which the bounds alone decide a reified constraint.
    reif   = 1'b0;
    cond_t = 1'b0;
    cond_f = 1'b0;
    unique case (action_i) inside
      ACT_EQ_REIF: begin
        reif   = 1'b1;
        cond_t = same_fixed;
        cond_f = disjoint;
      end
      ACT_LE_REIF: begin
        reif   = 1'b1;
        cond_t = (a0.hi <= b0.lo);
        cond_f = (b0.hi < a0.lo);
      end
      ACT_LT_REIF: begin
        reif   = 1'b1;
        cond_t = (a0.hi < b0.lo);
        cond_f = (b0.hi <= a0.lo);
      end
      ACT_NE_REIF: begin
        reif   = 1'b1;
        cond_t = disjoint;
        cond_f = same_fixed;
      end
      default: begin
        reif = 1'b0;
      end
    endcase

    // Fix the truth variable, flagging a clash with a value already set.
    r1          = r0;
    assign_fail = 1'b0;
    if (reif && (cond_t || cond_f)) begin
      if (r0 == TRUTH_UNBOUND) begin
        r1 = cond_t ? TRUTH_TRUE : TRUTH_FALSE;
      end else if (r0 != (cond_t ? TRUTH_TRUE : TRUTH_FALSE)) begin
        assign_fail = 1'b1;
      end
    end
    is_t = !assign_fail && (r1 == TRUTH_TRUE);
    is_f = !assign_fail && (r1 == TRUTH_FALSE);

    // Pick which propagation applies.
    sel_abs   = 1'b0;
    sel_eq    = 1'b0;
    sel_ne    = 1'b0;
    sel_le_ab = 1'b0;
    sel_le_ba = 1'b0;
    unique case (action_i) inside
      ACT_ABS:              sel_abs   = 1'b1;
      ACT_EQ:               sel_eq    = 1'b1;
      ACT_LE, ACT_LT:       sel_le_ab = 1'b1;
      ACT_NE:               sel_ne    = 1'b1;
      ACT_EQ_REIF: begin
        sel_eq = is_t;
        sel_ne = is_f;
      end
      ACT_LE_REIF, ACT_LT_REIF: begin
        sel_le_ab = is_t;
        sel_le_ba = is_f;
      end
      ACT_NE_REIF: begin
        sel_ne = is_t;
        sel_eq = is_f;
      end
      default: begin
        sel_abs = 1'b0;
      end
    endcase

    // Result mux.
    a_res     = a0;
    b_res     = b0;
    hole_a    = 1'b0;
    hole_b    = 1'b0;
    prop_fail = 1'b0;
    if (sel_abs) begin
      a_res     = aa;
      b_res     = ab2;
      prop_fail = abs_fail;
    end else if (sel_eq) begin
      a_res     = eq_rng;
      b_res     = eq_rng;
      prop_fail = eq_fail;
    end else if (sel_ne) begin
      if (b_fixed) begin
        a_res  = rm_a.d;
        hole_a = rm_a.hole;
      end
      if (a_fixed) begin
        b_res  = rm_b.d;
        hole_b = rm_b.hole;
      end
      prop_fail = ne_fail;
    end else if (sel_le_ab) begin
      a_res     = le_ab.x;
      b_res     = le_ab.y;
      prop_fail = le_ab.fail;
    end else if (sel_le_ba) begin
      a_res     = le_ba.y;
      b_res     = le_ba.x;
      prop_fail = le_ba.fail;
    end

    // A failure returns the bounds and truth value as they arrived.
    fail = empty || assign_fail || prop_fail;
    if (fail) begin
      a_res  = a0;
      b_res  = b0;
      r1     = r0;
      hole_a = 1'b0;
      hole_b = 1'b0;
    end

    new_a_low_o           = a_res.lo[VALUE_WIDTH-1:0];
    new_a_high_o          = a_res.hi[VALUE_WIDTH-1:0];
    new_b_low_o           = b_res.lo[VALUE_WIDTH-1:0];
    new_b_high_o          = b_res.hi[VALUE_WIDTH-1:0];
    a_hole_value_o        = hole_a ? b_low_i : '0;
    b_hole_value_o        = hole_b ? a_low_i : '0;
    status_o.truth        = r1;
    status_o.a_hole_valid = hole_a;
    status_o.b_hole_valid = hole_b;
    status_o.failed       = fail;
  end

endmodule

### hdl/binary_int_constraint_bounds_propagator.sv
// Top level of the binary integer constraint bounds propagator.
// Depends on bicbp_pkg and bicbp_core.
//
// Use: one constraint item enters on the input channel (in_valid_i/in_ready_o)
// with its kind, the bounds of a and b and the truth variable; one result item
// leaves on the output channel (out_valid_o/out_ready_i) with the narrowed
// bounds, the new truth value, the value-removal requests and the fail flag.
// The item is held in an input register, the propagation runs through
// combinational compare-and-select logic, and the result is captured in an
// output register when that register is empty or being emptied.
// Throughput is one item per cycle; both registers advance together while
// the receiver takes results, so a full pipeline holds two items.
// When the receiver stalls, the output register holds its result and the
// input register fills; in_ready_o falls only once both are occupied.
// Reset empties both stages; no result is pending afterwards and no clearing
// is needed since the block keeps no state between items.
module binary_int_constraint_bounds_propagator #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [3:0]                    action_i,
  input  logic signed [VALUE_WIDTH-1:0] a_low_i,
  input  logic signed [VALUE_WIDTH-1:0] a_high_i,
  input  logic signed [VALUE_WIDTH-1:0] b_low_i,
  input  logic signed [VALUE_WIDTH-1:0] b_high_i,
  input  logic [1:0]                    truth_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] new_a_low_o,
  output logic signed [VALUE_WIDTH-1:0] new_a_high_o,
  output logic signed [VALUE_WIDTH-1:0] new_b_low_o,
  output logic signed [VALUE_WIDTH-1:0] new_b_high_o,
  output logic [1:0]                    truth_out_o,
  output logic                          a_hole_valid_o,
  output logic signed [VALUE_WIDTH-1:0] a_hole_value_o,
  output logic                          b_hole_valid_o,
  output logic signed [VALUE_WIDTH-1:0] b_hole_value_o,
  output logic                          failed_o
);
  import bicbp_pkg::*;

  logic                          s1_valid_q, s2_valid_q;
  logic                          s1_advance, s2_load;
  logic [3:0]                    action_q;
  logic signed [VALUE_WIDTH-1:0] a_low_q, a_high_q, b_low_q, b_high_q;
  logic [1:0]                    truth_q;

  logic signed [VALUE_WIDTH-1:0] new_a_low_d, new_a_high_d, new_b_low_d, new_b_high_d;
  logic signed [VALUE_WIDTH-1:0] a_hole_value_d, b_hole_value_d;
  status_t                       status_d;

  logic signed [VALUE_WIDTH-1:0] new_a_low_q, new_a_high_q, new_b_low_q, new_b_high_q;
  logic signed [VALUE_WIDTH-1:0] a_hole_value_q, b_hole_value_q;
  status_t                       status_q;

  // Handshake: the result register loads when empty or being emptied.
  assign s2_load    = !s2_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s2_load;
  assign s1_advance = in_valid_i && in_ready_o;

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_load) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      action_q <= action_i;
      a_low_q  <= a_low_i;
      a_high_q <= a_high_i;
      b_low_q  <= b_low_i;
      b_high_q <= b_high_i;
      truth_q  <= truth_in_i;
    end
  end

  // Propagation datapath.
  bicbp_core #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_core (
    .action_i      (action_e'(action_q)),
    .a_low_i       (a_low_q),
    .a_high_i      (a_high_q),
    .b_low_i       (b_low_q),
    .b_high_i      (b_high_q),
    .truth_i       (truth_q),
    .new_a_low_o   (new_a_low_d),
    .new_a_high_o  (new_a_high_d),
    .new_b_low_o   (new_b_low_d),
    .new_b_high_o  (new_b_high_d),
    .a_hole_value_o(a_hole_value_d),
    .b_hole_value_o(b_hole_value_d),
    .status_o      (status_d)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (s2_load && s1_valid_q) begin
      new_a_low_q    <= new_a_low_d;
      new_a_high_q   <= new_a_high_d;
      new_b_low_q    <= new_b_low_d;
      new_b_high_q   <= new_b_high_d;
      a_hole_value_q <= a_hole_value_d;
      b_hole_value_q <= b_hole_value_d;
      status_q       <= status_d;
    end
  end

  assign out_valid_o    = s2_valid_q;
  assign new_a_low_o    = new_a_low_q;
  assign new_a_high_o   = new_a_high_q;
  assign new_b_low_o    = new_b_low_q;
  assign new_b_high_o   = new_b_high_q;
  assign truth_out_o    = status_q.truth;
  assign a_hole_valid_o = status_q.a_hole_valid;
  assign a_hole_value_o = a_hole_value_q;
  assign b_hole_valid_o = status_q.b_hole_valid;
  assign b_hole_value_o = b_hole_value_q;
  assign failed_o       = status_q.failed;

endmodule
